FILE: sv/cubic_bezier_tessellator_assert.svh
// Assertion macros for the Bezier tessellator.
// Each one is compiled out when ASSERT_OFF is defined.
`ifndef CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication: the consequent must hold when the antecedent does.
`define CBT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbt: same-cycle implication failed");

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbt: next-cycle implication failed");

`else

`define CBT_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define CBT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/cbt_pkg.sv
`timescale 1ns / 1ps

package cbt_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int SEG_W   = 6;
   localparam int SCALE_W = 16;

   localparam int MAX_SEGMENTS_DEF = 63;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

   // curve parameter t and u = 1 - t, Q0.16 with room for 1.0
   localparam int T_W  = 17;
   localparam int T3_W = 18;
   localparam logic [T_W-1:0] ONE_T = 17'h1_0000;

   // reciprocal divide 2^16 / n, one quotient bit per cycle
   localparam int DIV_STEPS = 17;
   localparam int DIV_CNT_W = 5;

   // datapath widths
   localparam int UU_W    = 33;
   localparam int TT_W    = 32;
   localparam int W_W     = 25;
   localparam int W_SHIFT = 24;
   localparam int ACC_W   = 59;
   localparam int P_W     = 35;
   localparam int MUL_A_W = 37;
   localparam int MUL_B_W = 26;
   localparam int PROD_W  = 63;
   localparam int S_SHIFT = 8;
   localparam int SCL_W   = 43;

   localparam longint HALF_W = 64'd8388608;
   localparam longint HALF_S = 64'd128;

   localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIV,
      ST_PREP,
      ST_UU,
      ST_TT,
      ST_W0,
      ST_W1,
      ST_W2,
      ST_W3,
      ST_M0,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_MA,
      ST_RND,
      ST_SCL,
      ST_SAT,
      ST_EMIT,
      ST_STEP
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_UU,
      MUL_TT,
      MUL_W0,
      MUL_W1,
      MUL_W2,
      MUL_W3,
      MUL_PT0,
      MUL_PT1,
      MUL_PT2,
      MUL_PT3,
      MUL_SCALE
   } mul_op_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_UU,
      WB_TT,
      WB_W0,
      WB_W1,
      WB_W2,
      WB_W3,
      WB_ACC_LOAD,
      WB_ACC_ADD,
      WB_P_ROUND,
      WB_P_END,
      WB_VX,
      WB_VY
   } wb_op_type;

   typedef struct packed {
      logic       load;
      logic       prep;
      logic       step;
      logic       emit;
      logic       axis;
      logic       last;
      mul_op_type mul_op;
      wb_op_type  wb_op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic final_now;
      logic final_after_step;
      logic out_free;
   } status_type;

endpackage

FILE: sv/cbt_div.sv
`timescale 1ns / 1ps

module cbt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cbt_pkg::SEG_W-1:0]  divisor,
   output logic                       busy,
   output logic [cbt_pkg::T_W-1:0]    quotient,
   output logic [cbt_pkg::SEG_W-1:0]  remainder
);

   logic [cbt_pkg::T_W-1:0]       num_ff, num_in;
   logic [cbt_pkg::T_W-1:0]       quo_ff, quo_in;
   logic [cbt_pkg::SEG_W-1:0]     rem_ff, rem_in;
   logic [cbt_pkg::SEG_W-1:0]     den_ff, den_in;
   logic [cbt_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;

   logic [cbt_pkg::SEG_W:0] trial;
   logic [cbt_pkg::SEG_W:0] diff;
   logic                    fits;

   // restoring divide of 2^16 by the segment count
   always_comb begin
      trial = {rem_ff, num_ff[cbt_pkg::T_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};

      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      if (start) begin
         num_in = cbt_pkg::ONE_T;
         quo_in = '0;
         rem_in = '0;
         den_in = divisor;
         cnt_in = cbt_pkg::DIV_CNT_W'(cbt_pkg::DIV_STEPS);
      end else if (cnt_ff != '0) begin
         num_in = {num_ff[cbt_pkg::T_W-2:0], 1'b0};
         quo_in = {quo_ff[cbt_pkg::T_W-2:0], fits};
         rem_in = fits ? diff[cbt_pkg::SEG_W-1:0] : trial[cbt_pkg::SEG_W-1:0];
         cnt_in = cnt_ff - cbt_pkg::DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/cbt_datapath.sv
`timescale 1ns / 1ps
`include "cubic_bezier_tessellator_assert.svh"

module cbt_datapath #(
   parameter int MAX_SEGMENTS = cbt_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cbt_pkg::cmd_type                   cmd,
   output cbt_pkg::status_type                status,
   input  logic                               csr_wr_en,
   input  logic [cbt_pkg::SCALE_W-1:0]        csr_wr_data,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl1_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl1_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl2_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl2_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_end_y,
   input  logic [cbt_pkg::SEG_W-1:0]          req_segment_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cbt_pkg::COORD_W-1:0] rsp_vertex_x,
   output logic signed [cbt_pkg::COORD_W-1:0] rsp_vertex_y,
   output logic                               rsp_last_vertex
);

   logic [cbt_pkg::SCALE_W-1:0]        scale_ff, scale_in;
   logic signed [cbt_pkg::COORD_W-1:0] pt_x_ff [4];
   logic signed [cbt_pkg::COORD_W-1:0] pt_x_in [4];
   logic signed [cbt_pkg::COORD_W-1:0] pt_y_ff [4];
   logic signed [cbt_pkg::COORD_W-1:0] pt_y_in [4];
   logic [cbt_pkg::SEG_W-1:0]          seg_ff, seg_in;
   logic [cbt_pkg::SEG_W-1:0]          idx_ff, idx_in;
   logic [cbt_pkg::T_W-1:0]            t_ff, t_in;
   logic [cbt_pkg::SEG_W-1:0]          r_ff, r_in;
   logic [cbt_pkg::T_W-1:0]            u_ff, u_in;
   logic [cbt_pkg::T3_W-1:0]           t3_ff, t3_in;
   logic [cbt_pkg::T3_W-1:0]           u3_ff, u3_in;
   logic [cbt_pkg::UU_W-1:0]           uu_ff, uu_in;
   logic [cbt_pkg::TT_W-1:0]           tt_ff, tt_in;
   logic [cbt_pkg::W_W-1:0]            w_ff [4];
   logic [cbt_pkg::W_W-1:0]            w_in [4];
   logic signed [cbt_pkg::ACC_W-1:0]   acc_ff, acc_in;
   logic signed [cbt_pkg::P_W-1:0]     p_ff, p_in;
   logic signed [cbt_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic signed [cbt_pkg::COORD_W-1:0] vx_ff, vx_in;
   logic signed [cbt_pkg::COORD_W-1:0] vy_ff, vy_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [cbt_pkg::COORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [cbt_pkg::COORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               div_busy;
   logic [cbt_pkg::T_W-1:0]            div_quo;
   logic [cbt_pkg::SEG_W-1:0]          div_rem;

   logic [cbt_pkg::SEG_W-1:0]          seg_sat;
   logic [cbt_pkg::SEG_W:0]            step_sum;
   logic                               step_wrap;
   logic [cbt_pkg::T_W-1:0]            u_next;
   logic signed [cbt_pkg::COORD_W-1:0] pt_axis [4];
   logic signed [cbt_pkg::MUL_A_W-1:0] mul_a;
   logic signed [cbt_pkg::MUL_B_W-1:0] mul_b;
   logic [cbt_pkg::PROD_W-1:0]         prod_rnd;
   logic [cbt_pkg::W_W-1:0]            w_rnd;
   logic signed [cbt_pkg::ACC_W-1:0]   prod_acc;
   logic signed [cbt_pkg::ACC_W-1:0]   acc_rnd;
   logic [cbt_pkg::PROD_W-1:0]         s_rnd;
   logic signed [cbt_pkg::SCL_W-1:0]   s_val;
   logic signed [cbt_pkg::COORD_W-1:0] sat_val;
   logic                               out_free;
   logic                               final_now;

   assign seg_sat = (req_segment_count > cbt_pkg::SEG_W'(MAX_SEGMENTS)) ?
                    cbt_pkg::SEG_W'(MAX_SEGMENTS) : req_segment_count;

   cbt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.load),
      .divisor   (seg_sat),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // the coordinate of each control point on the axis being worked
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         pt_axis[k] = cmd.axis ? pt_y_ff[k] : pt_x_ff[k];
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         cbt_pkg::MUL_UU: begin
            mul_a = cbt_pkg::MUL_A_W'(u_ff);
            mul_b = cbt_pkg::MUL_B_W'(u_ff);
         end
         cbt_pkg::MUL_TT: begin
            mul_a = cbt_pkg::MUL_A_W'(t_ff);
            mul_b = cbt_pkg::MUL_B_W'(t_ff);
         end
         cbt_pkg::MUL_W0: begin
            mul_a = cbt_pkg::MUL_A_W'(uu_ff);
            mul_b = cbt_pkg::MUL_B_W'(u_ff);
         end
         cbt_pkg::MUL_W1: begin
            mul_a = cbt_pkg::MUL_A_W'(uu_ff);
            mul_b = cbt_pkg::MUL_B_W'(t3_ff);
         end
         cbt_pkg::MUL_W2: begin
            mul_a = cbt_pkg::MUL_A_W'(tt_ff);
            mul_b = cbt_pkg::MUL_B_W'(u3_ff);
         end
         cbt_pkg::MUL_W3: begin
            mul_a = cbt_pkg::MUL_A_W'(tt_ff);
            mul_b = cbt_pkg::MUL_B_W'(t_ff);
         end
         cbt_pkg::MUL_PT0: begin
            mul_a = cbt_pkg::MUL_A_W'(pt_axis[0]);
            mul_b = cbt_pkg::MUL_B_W'(w_ff[0]);
         end
         cbt_pkg::MUL_PT1: begin
            mul_a = cbt_pkg::MUL_A_W'(pt_axis[1]);
            mul_b = cbt_pkg::MUL_B_W'(w_ff[1]);
         end
         cbt_pkg::MUL_PT2: begin
            mul_a = cbt_pkg::MUL_A_W'(pt_axis[2]);
            mul_b = cbt_pkg::MUL_B_W'(w_ff[2]);
         end
         cbt_pkg::MUL_PT3: begin
            mul_a = cbt_pkg::MUL_A_W'(pt_axis[3]);
            mul_b = cbt_pkg::MUL_B_W'(w_ff[3]);
         end
         cbt_pkg::MUL_SCALE: begin
            mul_a = cbt_pkg::MUL_A_W'(p_ff);
            mul_b = cbt_pkg::MUL_B_W'(scale_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   // rounding and saturation on the registered product
   always_comb begin
      prod_rnd = prod_ff + cbt_pkg::PROD_W'(cbt_pkg::HALF_W);
      w_rnd    = prod_rnd[cbt_pkg::W_W+cbt_pkg::W_SHIFT-1:cbt_pkg::W_SHIFT];
      prod_acc = signed'(prod_ff[cbt_pkg::ACC_W-1:0]);
      acc_rnd  = acc_ff + cbt_pkg::ACC_W'(cbt_pkg::HALF_W);
      s_rnd    = prod_ff + cbt_pkg::PROD_W'(cbt_pkg::HALF_S);
      s_val    = signed'(s_rnd[cbt_pkg::SCL_W+cbt_pkg::S_SHIFT-1:cbt_pkg::S_SHIFT]);
      if (!s_val[cbt_pkg::SCL_W-1] && (|s_val[cbt_pkg::SCL_W-2:cbt_pkg::COORD_W-1])) begin
         sat_val = cbt_pkg::COORD_MAX;
      end else if (s_val[cbt_pkg::SCL_W-1] &&
                   !(&s_val[cbt_pkg::SCL_W-2:cbt_pkg::COORD_W-1])) begin
         sat_val = cbt_pkg::COORD_MIN;
      end else begin
         sat_val = s_val[cbt_pkg::COORD_W-1:0];
      end
   end

   // next t by whole and fractional step of 2^16 / n
   always_comb begin
      step_sum  = {1'b0, r_ff} + {1'b0, div_rem};
      step_wrap = step_sum >= {1'b0, seg_ff};
      u_next    = cbt_pkg::ONE_T - t_ff;
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign final_now = idx_ff == seg_ff;

   always_comb begin
      scale_in     = scale_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      u_in         = u_ff;
      t3_in        = t3_ff;
      u3_in        = u3_ff;
      uu_in        = uu_ff;
      tt_in        = tt_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      p_in         = p_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_wr_en) begin
         scale_in = csr_wr_data;
      end

      if (cmd.load) begin
         pt_x_in[0] = req_start_x;
         pt_y_in[0] = req_start_y;
         pt_x_in[1] = req_ctrl1_x;
         pt_y_in[1] = req_ctrl1_y;
         pt_x_in[2] = req_ctrl2_x;
         pt_y_in[2] = req_ctrl2_y;
         pt_x_in[3] = req_end_x;
         pt_y_in[3] = req_end_y;
         seg_in     = seg_sat;
         idx_in     = '0;
         t_in       = '0;
         r_in       = seg_sat >> 1;
      end

      if (cmd.step) begin
         idx_in = idx_ff + cbt_pkg::SEG_W'(1);
         t_in   = t_ff + div_quo + cbt_pkg::T_W'(step_wrap);
         r_in   = step_wrap ? cbt_pkg::SEG_W'(step_sum - {1'b0, seg_ff}) :
                              step_sum[cbt_pkg::SEG_W-1:0];
      end

      if (cmd.prep) begin
         u_in  = u_next;
         u3_in = {u_next, 1'b0} + cbt_pkg::T3_W'(u_next);
         t3_in = {t_ff, 1'b0} + cbt_pkg::T3_W'(t_ff);
      end

      case (cmd.wb_op)
         cbt_pkg::WB_UU:       uu_in  = prod_ff[cbt_pkg::UU_W-1:0];
         cbt_pkg::WB_TT:       tt_in  = prod_ff[cbt_pkg::TT_W-1:0];
         cbt_pkg::WB_W0:       w_in[0] = w_rnd;
         cbt_pkg::WB_W1:       w_in[1] = w_rnd;
         cbt_pkg::WB_W2:       w_in[2] = w_rnd;
         cbt_pkg::WB_W3:       w_in[3] = w_rnd;
         cbt_pkg::WB_ACC_LOAD: acc_in = prod_acc;
         cbt_pkg::WB_ACC_ADD:  acc_in = acc_ff + prod_acc;
         cbt_pkg::WB_P_ROUND:  p_in   = acc_rnd[cbt_pkg::ACC_W-1:cbt_pkg::W_SHIFT];
         cbt_pkg::WB_P_END:    p_in   = cbt_pkg::P_W'(pt_axis[3]);
         cbt_pkg::WB_VX:       vx_in  = sat_val;
         cbt_pkg::WB_VY:       vy_in  = sat_val;
         default: begin
         end
      endcase

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = vx_ff;
         rsp_y_in     = vy_ff;
         rsp_last_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= cbt_pkg::SCALE_RESET;
         seg_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_x_ff     <= pt_x_in;
      pt_y_ff     <= pt_y_in;
      t_ff        <= t_in;
      r_ff        <= r_in;
      u_ff        <= u_in;
      t3_ff       <= t3_in;
      u3_ff       <= u3_in;
      uu_ff       <= uu_in;
      tt_ff       <= tt_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      prod_ff     <= prod_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.div_busy         = div_busy;
   assign status.final_now        = final_now;
   assign status.final_after_step = (idx_ff + cbt_pkg::SEG_W'(1)) == seg_ff;
   assign status.out_free         = out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_vertex_x    = rsp_x_ff;
   assign rsp_vertex_y    = rsp_y_ff;
   assign rsp_last_vertex = rsp_last_ff;

   `CBT_ASSERT_IMPL(a_emit_into_free_slot, clock, reset, cmd.emit, out_free)
   `CBT_ASSERT_IMPL(a_step_before_end, clock, reset, cmd.step, !final_now)
   `CBT_ASSERT_IMPL(a_prep_after_divide, clock, reset, cmd.prep, !div_busy)
   `CBT_ASSERT_IMPL(a_acc_add_follows_point_mul, clock, reset, cmd.wb_op == cbt_pkg::WB_ACC_ADD, $past(cmd.mul_op) == cbt_pkg::MUL_PT1 || $past(cmd.mul_op) == cbt_pkg::MUL_PT2 || $past(cmd.mul_op) == cbt_pkg::MUL_PT3)

endmodule

FILE: sv/cbt_ctrl.sv
`timescale 1ns / 1ps

module cbt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cbt_pkg::status_type status,
   output cbt_pkg::cmd_type    cmd
);

   cbt_pkg::state_type state_ff, state_in;
   logic               axis_ff, axis_in;
   logic               last_ff, last_in;

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      last_in  = last_ff;
      case (state_ff)
         cbt_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = cbt_pkg::ST_DIV;
               axis_in  = 1'b0;
               last_in  = 1'b0;
            end
         end
         cbt_pkg::ST_DIV: begin
            if (status.final_now) begin
               last_in  = 1'b1;
               state_in = cbt_pkg::ST_RND;
            end else if (!status.div_busy) begin
               state_in = cbt_pkg::ST_PREP;
            end
         end
         cbt_pkg::ST_PREP: state_in = cbt_pkg::ST_UU;
         cbt_pkg::ST_UU:   state_in = cbt_pkg::ST_TT;
         cbt_pkg::ST_TT:   state_in = cbt_pkg::ST_W0;
         cbt_pkg::ST_W0:   state_in = cbt_pkg::ST_W1;
         cbt_pkg::ST_W1:   state_in = cbt_pkg::ST_W2;
         cbt_pkg::ST_W2:   state_in = cbt_pkg::ST_W3;
         cbt_pkg::ST_W3:   state_in = cbt_pkg::ST_M0;
         cbt_pkg::ST_M0:   state_in = cbt_pkg::ST_M1;
         cbt_pkg::ST_M1:   state_in = cbt_pkg::ST_M2;
         cbt_pkg::ST_M2:   state_in = cbt_pkg::ST_M3;
         cbt_pkg::ST_M3:   state_in = cbt_pkg::ST_MA;
         cbt_pkg::ST_MA:   state_in = cbt_pkg::ST_RND;
         cbt_pkg::ST_RND:  state_in = cbt_pkg::ST_SCL;
         cbt_pkg::ST_SCL:  state_in = cbt_pkg::ST_SAT;
         cbt_pkg::ST_SAT: begin
            if (!axis_ff) begin
               axis_in  = 1'b1;
               state_in = last_ff ? cbt_pkg::ST_RND : cbt_pkg::ST_M0;
            end else begin
               state_in = cbt_pkg::ST_EMIT;
            end
         end
         cbt_pkg::ST_EMIT: begin
            if (status.out_free) begin
               axis_in  = 1'b0;
               state_in = last_ff ? cbt_pkg::ST_IDLE : cbt_pkg::ST_STEP;
            end
         end
         cbt_pkg::ST_STEP: begin
            if (status.final_after_step) begin
               last_in  = 1'b1;
               state_in = cbt_pkg::ST_RND;
            end else begin
               state_in = cbt_pkg::ST_PREP;
            end
         end
         default: state_in = cbt_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      req_stall  = 1'b1;
      cmd        = '0;
      cmd.axis   = axis_ff;
      cmd.last   = last_ff;
      cmd.mul_op = cbt_pkg::MUL_NONE;
      cmd.wb_op  = cbt_pkg::WB_NONE;
      case (state_ff)
         cbt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         cbt_pkg::ST_PREP: cmd.prep = 1'b1;
         cbt_pkg::ST_UU:   cmd.mul_op = cbt_pkg::MUL_UU;
         cbt_pkg::ST_TT: begin
            cmd.mul_op = cbt_pkg::MUL_TT;
            cmd.wb_op  = cbt_pkg::WB_UU;
         end
         cbt_pkg::ST_W0: begin
            cmd.mul_op = cbt_pkg::MUL_W0;
            cmd.wb_op  = cbt_pkg::WB_TT;
         end
         cbt_pkg::ST_W1: begin
            cmd.mul_op = cbt_pkg::MUL_W1;
            cmd.wb_op  = cbt_pkg::WB_W0;
         end
         cbt_pkg::ST_W2: begin
            cmd.mul_op = cbt_pkg::MUL_W2;
            cmd.wb_op  = cbt_pkg::WB_W1;
         end
         cbt_pkg::ST_W3: begin
            cmd.mul_op = cbt_pkg::MUL_W3;
            cmd.wb_op  = cbt_pkg::WB_W2;
         end
         cbt_pkg::ST_M0: begin
            cmd.mul_op = cbt_pkg::MUL_PT0;
            cmd.wb_op  = axis_ff ? cbt_pkg::WB_NONE : cbt_pkg::WB_W3;
         end
         cbt_pkg::ST_M1: begin
            cmd.mul_op = cbt_pkg::MUL_PT1;
            cmd.wb_op  = cbt_pkg::WB_ACC_LOAD;
         end
         cbt_pkg::ST_M2: begin
            cmd.mul_op = cbt_pkg::MUL_PT2;
            cmd.wb_op  = cbt_pkg::WB_ACC_ADD;
         end
         cbt_pkg::ST_M3: begin
            cmd.mul_op = cbt_pkg::MUL_PT3;
            cmd.wb_op  = cbt_pkg::WB_ACC_ADD;
         end
         cbt_pkg::ST_MA:   cmd.wb_op = cbt_pkg::WB_ACC_ADD;
         cbt_pkg::ST_RND:  cmd.wb_op = last_ff ? cbt_pkg::WB_P_END : cbt_pkg::WB_P_ROUND;
         cbt_pkg::ST_SCL:  cmd.mul_op = cbt_pkg::MUL_SCALE;
         cbt_pkg::ST_SAT:  cmd.wb_op = axis_ff ? cbt_pkg::WB_VY : cbt_pkg::WB_VX;
         cbt_pkg::ST_EMIT: cmd.emit = status.out_free;
         cbt_pkg::ST_STEP: cmd.step = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cbt_pkg::ST_IDLE;
         axis_ff  <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         last_ff  <= last_in;
      end
   end

endmodule

FILE: sv/cubic_bezier_tessellator.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  four control points (Q16.16), segment count
// rsp_      out        rsp_valid/rsp_stall  vertex x/y (Q16.16, scaled), last vertex flag
// csr_      in         csr_wr_en            content scale factor, Q8.8
//
// One curve of n segments is accepted and 2^16/n is formed in the bit-serial divider;
// then each inner vertex is computed and finally the destination vertex, all paced by
// the single shared 37x26 multiplier (6 products for the Bernstein weights, then 5 per
// axis). A zero count skips the divide.
// Reset is synchronous and active high; it restores the scale factor to 1.0.
// A stalled result holds in the output register and the controller waits in its emit
// state; a new curve is taken only once the last vertex of the previous one is emitted.

module cubic_bezier_tessellator #(
   parameter int MAX_SEGMENTS = cbt_pkg::MAX_SEGMENTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [cbt_pkg::SCALE_W-1:0]        csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_start_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_start_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl1_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl1_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl2_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_ctrl2_y,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_end_x,
   input  logic signed [cbt_pkg::COORD_W-1:0] req_end_y,
   input  logic [cbt_pkg::SEG_W-1:0]          req_segment_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cbt_pkg::COORD_W-1:0] rsp_vertex_x,
   output logic signed [cbt_pkg::COORD_W-1:0] rsp_vertex_y,
   output logic                               rsp_last_vertex
);

   // controller to datapath: one command word a cycle, status back
   cbt_pkg::cmd_type    cmd;
   cbt_pkg::status_type status;

   // sequencer: weights, per-axis sums for inner vertices; scale, emit for all
   cbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: held curve, t stepping, shared multiplier, output register
   cbt_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_ctrl1_x       (req_ctrl1_x),
      .req_ctrl1_y       (req_ctrl1_y),
      .req_ctrl2_x       (req_ctrl2_x),
      .req_ctrl2_y       (req_ctrl2_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_segment_count (req_segment_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_last_vertex   (rsp_last_vertex)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int CLK_PERIOD = 20;

   localparam int                  COORD_W          = cbt_pkg::COORD_W;
   localparam int                  SEG_W            = cbt_pkg::SEG_W;
   localparam int                  SCALE_W          = cbt_pkg::SCALE_W;
   localparam int                  MAX_SEGMENTS_DEF = cbt_pkg::MAX_SEGMENTS_DEF;
   localparam logic [SCALE_W-1:0]  SCALE_RESET      = cbt_pkg::SCALE_RESET;
   localparam logic [COORD_W-1:0]  COORD_MAX        = cbt_pkg::COORD_MAX;
   localparam logic [COORD_W-1:0]  COORD_MIN        = cbt_pkg::COORD_MIN;

   // The slowest curve has 63 segments, but its vertices leave one at a time as each is
   // computed. The longest stretch without any transaction is therefore the deliberate
   // receiver hold-off plus one vertex, well inside this bound.
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int STUCK_LIMIT     = 5000;
   // The block goes idle as soon as the destination vertex leaves, so a short tail will do.
   localparam int TAIL_CYCLES     = 40;
   localparam int ITEMS_PER_BLOCK = 34;

   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] ctrl1_x;
      logic [COORD_W-1:0] ctrl1_y;
      logic [COORD_W-1:0] ctrl2_x;
      logic [COORD_W-1:0] ctrl2_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [SEG_W-1:0]   segs;
   } curve_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               last;
   } vertex_type;

   // Directed curves. Where typed is set, every vertex of the curve must equal
   // (typed_x, typed_y); elsewhere the vertices come from the predictor.
   typedef struct packed {
      logic [SCALE_W-1:0] scale;
      curve_type          curve;
      logic               typed;
      logic [COORD_W-1:0] typed_x;
      logic [COORD_W-1:0] typed_y;
   } directed_row_type;

   localparam int NUM_DIRECTED = 18;

   localparam directed_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      // zero segments: the destination alone, first at both coordinate extremes, then near zero
      '{16'd256, '{32'h0000_0064, 32'h0000_00C8, 32'h0000_012C, 32'h0000_0190,
                   32'h0000_01F4, 32'h0000_0258, COORD_MAX, COORD_MIN, 6'd0},
        1'b1, COORD_MAX, COORD_MIN},
      '{16'd256, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'hFFFF_FFFF, 32'h0000_0001, 6'd0},
        1'b1, 32'hFFFF_FFFF, 32'h0000_0001},
      // one segment, then the largest count
      '{16'd256, '{32'h0, 32'h0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   32'h0001_0000, 32'h0004_0000, 32'h0, 6'd1},
        1'b0, 32'h0, 32'h0},
      '{16'd256, '{32'hFFF0_0000, 32'h0010_0000, 32'h0008_0000, 32'hFFF8_0000,
                   32'h0001_8000, 32'h0004_4000, 32'h0012_3456, 32'hFFED_CBA9, 6'd63},
        1'b0, 32'h0, 32'h0},
      // all points at one extreme, then alternating extremes
      '{16'd256, '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                   COORD_MAX, COORD_MAX, 6'd2},
        1'b0, 32'h0, 32'h0},
      '{16'd256, '{COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                   COORD_MIN, COORD_MIN, 6'd3},
        1'b0, 32'h0, 32'h0},
      '{16'd256, '{COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                   COORD_MIN, COORD_MAX, 6'd5},
        1'b0, 32'h0, 32'h0},
      // checkerboard patterns on both the coordinates and the count
      '{16'd256, '{32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                   32'h5555_5555, 32'hAAAA_AAAA, 32'h7654_3210, 32'h89AB_CDEF, 6'd42},
        1'b0, 32'h0, 32'h0},
      '{16'd256, '{32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'hFFFF_FFFF,
                   32'h8000_0001, 32'h7FFF_FFFE, 32'h0, 32'h0, 6'd21},
        1'b0, 32'h0, 32'h0},
      // largest scale: saturation on both sides
      '{16'd65535, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                     COORD_MAX, COORD_MIN, 6'd0},
        1'b1, COORD_MAX, COORD_MIN},
      '{16'd65535, '{32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0200, 32'h0000_0300,
                     32'hFFFF_FC00, 32'h0000_0080, 32'h0000_0010, 32'hFFFF_FFF0, 6'd4},
        1'b0, 32'h0, 32'h0},
      '{16'd65535, '{32'h4000_0000, 32'hC000_0000, 32'h0100_0000, 32'hFF00_0000,
                     32'h0080_0000, 32'h0000_8000, 32'hE000_0000, 32'h2000_0000, 6'd7},
        1'b0, 32'h0, 32'h0},
      // zero scale: every vertex collapses to the origin
      '{16'd0, '{COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MIN, 6'd0},
        1'b1, 32'h0, 32'h0},
      '{16'd0, '{32'h1357_9BDF, 32'h2468_ACE0, 32'hFEDC_BA98, 32'h0123_4567,
                 32'h8765_4321, 32'h3C3C_3C3C, 32'hC3C3_C3C3, 32'h6666_6666, 6'd9},
        1'b1, 32'h0, 32'h0},
      // smallest scale: 256 LSB shrinks to one LSB, -256 LSB rounds to minus one LSB
      '{16'd1, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                 32'h0000_0100, 32'hFFFF_FF00, 6'd0},
        1'b1, 32'h0000_0001, 32'hFFFF_FFFF},
      '{16'd1, '{32'h7FFF_0000, 32'h8001_0000, 32'h0000_FFFF, 32'hFFFF_0001,
                 32'h0100_0000, 32'hFF00_0000, 32'h0000_0180, 32'hFFFF_FE80, 6'd6},
        1'b0, 32'h0, 32'h0},
      // half scale: exact halves round upwards
      '{16'd128, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                   32'h0000_0003, 32'hFFFF_FFFD, 6'd0},
        1'b1, 32'h0000_0002, 32'hFFFF_FFFF},
      '{16'd128, '{32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 32'hFFFF_FFFD,
                   32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0007, 32'hFFFF_FFF9, 6'd8},
        1'b0, 32'h0, 32'h0}
   };

   // Block ports; every input holds a known value from time zero
   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_wr_en         = 1'b0;
   logic [SCALE_W-1:0]   csr_wr_data       = SCALE_RESET;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   logic [COORD_W-1:0]   req_start_x       = '0;
   logic [COORD_W-1:0]   req_start_y       = '0;
   logic [COORD_W-1:0]   req_ctrl1_x       = '0;
   logic [COORD_W-1:0]   req_ctrl1_y       = '0;
   logic [COORD_W-1:0]   req_ctrl2_x       = '0;
   logic [COORD_W-1:0]   req_ctrl2_y       = '0;
   logic [COORD_W-1:0]   req_end_x         = '0;
   logic [COORD_W-1:0]   req_end_y         = '0;
   logic [SEG_W-1:0]     req_segment_count = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b1;
   logic [COORD_W-1:0]   rsp_vertex_x;
   logic [COORD_W-1:0]   rsp_vertex_y;
   logic                 rsp_last_vertex;

   // Travel with the payload, so they are sampled at the same edge as the transaction
   logic                 typed_row         = 1'b0;
   logic [COORD_W-1:0]   typed_x           = '0;
   logic [COORD_W-1:0]   typed_y           = '0;

   logic [SCALE_W-1:0]   scale_model       = SCALE_RESET;
   vertex_type           pending_vertices [$];
   int                   mismatch_count    = 0;
   int                   send_idle_pct     = 0;
   int                   recv_idle_pct     = 0;
   int                   hold_requests     = 0;
   int                   hold_served       = 0;
   int                   hold_left         = 0;
   int                   stuck_cycles      = 0;

   cubic_bezier_tessellator u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_ctrl1_x       (req_ctrl1_x),
      .req_ctrl1_y       (req_ctrl1_y),
      .req_ctrl2_x       (req_ctrl2_x),
      .req_ctrl2_y       (req_ctrl2_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_segment_count (req_segment_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_vertex_x      (rsp_vertex_x),
      .rsp_vertex_y      (rsp_vertex_y),
      .rsp_last_vertex   (rsp_last_vertex)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // Vertex prediction
   // ------------------------------------------------------------------

   // floor((v + 2^(s-1)) / 2^s); the arithmetic shift gives the floor for negatives
   function automatic longint round_shr(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint control_coord(curve_type c, int k, bit axis_y);
      logic [COORD_W-1:0] v;
      case (k)
         0:       v = axis_y ? c.start_y : c.start_x;
         1:       v = axis_y ? c.ctrl1_y : c.ctrl1_x;
         2:       v = axis_y ? c.ctrl2_y : c.ctrl2_x;
         default: v = axis_y ? c.end_y   : c.end_x;
      endcase
      return longint'($signed(v));
   endfunction

   // Bernstein sum at t = i/n: Q0.48 weights rounded to Q0.24, result Q16.16 unclamped
   function automatic longint bernstein_sum(curve_type c, int i, int n, bit axis_y);
      longint t;
      longint u;
      longint acc;
      longint wt [4];
      t = (longint'(i) * 65536 + longint'(n / 2)) / longint'(n);
      u = 65536 - t;
      wt[0] = u * u * u;
      wt[1] = 3 * u * u * t;
      wt[2] = 3 * u * t * t;
      wt[3] = t * t * t;
      acc = 0;
      for (int k = 0; k < 4; k++)
         acc += round_shr(wt[k], 24) * control_coord(c, k, axis_y);
      return round_shr(acc, 24);
   endfunction

   // Apply the Q8.8 scale with rounding, then clamp to the 32-bit range
   function automatic logic [COORD_W-1:0] scale_coord(longint p);
      longint r;
      r = round_shr(p * longint'(scale_model), 8);
      if (r > 64'sd2147483647)
         r = 64'sd2147483647;
      else if (r < -64'sd2147483648)
         r = -64'sd2147483648;
      return r[COORD_W-1:0];
   endfunction

   function automatic void tessellate_curve(curve_type c);
      int         n;
      vertex_type v;
      n = int'(c.segs);
      if (n > MAX_SEGMENTS_DEF)
         n = MAX_SEGMENTS_DEF;
      for (int i = 0; i < n; i++) begin
         v.x    = scale_coord(bernstein_sum(c, i, n, 1'b0));
         v.y    = scale_coord(bernstein_sum(c, i, n, 1'b1));
         v.last = 1'b0;
         pending_vertices.push_back(v);
      end
      // the destination is emitted as given, not evaluated at t = 1
      v.x    = scale_coord(control_coord(c, 3, 1'b0));
      v.y    = scale_coord(control_coord(c, 3, 1'b1));
      v.last = 1'b1;
      pending_vertices.push_back(v);
   endfunction

   function automatic void expect_typed(curve_type c, logic [COORD_W-1:0] vx,
                                        logic [COORD_W-1:0] vy);
      vertex_type v;
      for (int i = 0; i <= int'(c.segs); i++) begin
         v.x    = vx;
         v.y    = vy;
         v.last = (i == int'(c.segs));
         pending_vertices.push_back(v);
      end
   endfunction

   task automatic check_vertex();
      vertex_type want;
      if (pending_vertices.size() == 0) begin
         $error("unexpected vertex x=%0d y=%0d last=%0b",
                $signed(rsp_vertex_x), $signed(rsp_vertex_y), rsp_last_vertex);
         mismatch_count++;
      end else begin
         want = pending_vertices.pop_front();
         if (rsp_vertex_x !== want.x) begin
            $error("vertex_x: expected %0d, got %0d", $signed(want.x), $signed(rsp_vertex_x));
            mismatch_count++;
         end
         if (rsp_vertex_y !== want.y) begin
            $error("vertex_y: expected %0d, got %0d", $signed(want.y), $signed(rsp_vertex_y));
            mismatch_count++;
         end
         if (rsp_last_vertex !== want.last) begin
            $error("last_vertex: expected %0b, got %0b", want.last, rsp_last_vertex);
            mismatch_count++;
         end
      end
   endtask

   // Track the scale register, predict on every accepted curve, check every vertex.
   // All inputs change only through nonblocking assignments, so the values read here
   // are those that the block saw at this edge.
   always @(posedge clock) begin : monitor
      curve_type accepted;
      if (reset) begin
         scale_model = SCALE_RESET;
      end else begin
         if (csr_wr_en)
            scale_model = csr_wr_data;
         if (req_valid && !req_stall) begin
            accepted = '{req_start_x, req_start_y, req_ctrl1_x, req_ctrl1_y,
                         req_ctrl2_x, req_ctrl2_y, req_end_x, req_end_y, req_segment_count};
            if (typed_row)
               expect_typed(accepted, typed_x, typed_y);
            else
               tessellate_curve(accepted);
         end
         if (rsp_valid && !rsp_stall)
            check_vertex();
      end
   end

   // Receiver: random stalls, plus a long hold-off on request, counted here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_requests != hold_served) begin
         hold_served++;
         hold_left = HOLD_OFF_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // Abort if neither channel has moved a transaction for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Offer one curve, after a random number of idle cycles, and hold it until taken
   task automatic offer_curve(curve_type c, logic typed, logic [COORD_W-1:0] vx,
                              logic [COORD_W-1:0] vy);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_start_x       <= c.start_x;
      req_start_y       <= c.start_y;
      req_ctrl1_x       <= c.ctrl1_x;
      req_ctrl1_y       <= c.ctrl1_y;
      req_ctrl2_x       <= c.ctrl2_x;
      req_ctrl2_y       <= c.ctrl2_y;
      req_end_x         <= c.end_x;
      req_end_y         <= c.end_y;
      req_segment_count <= c.segs;
      typed_row         <= typed;
      typed_x           <= vx;
      typed_y           <= vy;
      req_valid         <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // Drop valid and wait for every predicted vertex. Advance one edge first so that the
   // prediction for the last transaction is already queued.
   task automatic drain_vertices();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_vertices.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_scale(logic [SCALE_W-1:0] value);
      drain_vertices();
      repeat (4) @(posedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   function automatic logic [COORD_W-1:0] random_coord(int kind);
      logic [COORD_W-1:0] v;
      v = $urandom;
      case (kind)
         0: return {{14{v[17]}}, v[17:0]};
         1: return {{6{v[25]}}, v[25:0]};
         2: begin
            case ($urandom_range(0, 5))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               3:       return '1;
               4:       return 32'h0000_0001;
               default: return v;
            endcase
         end
         default: return v;
      endcase
   endfunction

   // Mostly small segment counts keep the run short; one curve in eight spans the full range
   function automatic curve_type random_curve();
      curve_type c;
      int        kind;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: kind = 0;
         4, 5:       kind = 1;
         6:          kind = 2;
         default:    kind = 3;
      endcase
      c.start_x = random_coord(kind);
      c.start_y = random_coord(kind);
      c.ctrl1_x = random_coord(kind);
      c.ctrl1_y = random_coord(kind);
      c.ctrl2_x = random_coord(kind);
      c.ctrl2_y = random_coord(kind);
      c.end_x   = random_coord(kind);
      c.end_y   = random_coord(kind);
      if ($urandom_range(0, 7) == 0)
         c.segs = SEG_W'($urandom_range(0, 63));
      else
         c.segs = SEG_W'($urandom_range(0, 8));
      return c;
   endfunction

   initial begin : stimulus
      logic [SCALE_W-1:0] current_scale;
      logic [SCALE_W-1:0] next_scale;
      current_scale = SCALE_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed curves, with the sender idling rarely and the receiver often
      send_idle_pct = 6;
      recv_idle_pct = 65;
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (DIRECTED_ROWS[r].scale != current_scale) begin
            write_scale(DIRECTED_ROWS[r].scale);
            current_scale = DIRECTED_ROWS[r].scale;
         end
         offer_curve(DIRECTED_ROWS[r].curve, DIRECTED_ROWS[r].typed,
                     DIRECTED_ROWS[r].typed_x, DIRECTED_ROWS[r].typed_y);
      end

      // Random curves: three idling patterns, four scale settings under each
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 65;
            end
            1: begin
               send_idle_pct = 65;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int blk = 0; blk < 4; blk++) begin
            case (blk)
               0:       next_scale = SCALE_RESET;
               1:       next_scale = SCALE_W'($urandom_range(1, 65535));
               2:       next_scale = (mode == 0) ? 16'hFFFF : ((mode == 1) ? 16'd1 : 16'd0);
               default: next_scale = SCALE_W'($urandom_range(200, 320));
            endcase
            write_scale(next_scale);
            for (int k = 0; k < ITEMS_PER_BLOCK; k++) begin
               // hold off the receiver while curves keep coming, so the input backs up
               if (mode == 0 && blk == 1 && k == 10)
                  hold_requests++;
               // pause the sender until the block has delivered everything
               if (mode == 1 && blk == 2 && k == 17)
                  drain_vertices();
               offer_curve(random_curve(), 1'b0, '0, '0);
            end
         end
      end

      drain_vertices();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_vertices.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/cbt_pkg.sv
sv/cbt_div.sv
sv/cbt_datapath.sv
sv/cbt_ctrl.sv
sv/cubic_bezier_tessellator.sv
tb/testbench.sv
